// File: design/biobjective_lexmin_box_bounds_unit_macros.svh
// Assertion macros for the bi-objective box bounds unit.
// Used by the top level; relies on aclk and aresetn being in scope.
`ifndef BIOBJECTIVE_LEXMIN_BOX_BOUNDS_UNIT_MACROS_SVH
`define BIOBJECTIVE_LEXMIN_BOX_BOUNDS_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BBLB_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Same-cycle implication.
`define BBLB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBLB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bblb_pkg.sv
// Shared types, constants and helper functions of the box bounds unit.
// No dependencies; imported by the open map and the top level.
`timescale 1ns / 1ps

package bblb_pkg;

    localparam int FACILITY_COUNT = 1024;

    localparam int IDX_W  = 10;
    localparam int COST_W = 32;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Only indices below the facility count and representable in the index
    // field ever reach the map.
    localparam int MAP_DEPTH = (FACILITY_COUNT < (1 << IDX_W)) ? FACILITY_COUNT
                                                                : (1 << IDX_W);
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    localparam int                 EPOCH_W    = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ZERO = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE  = EPOCH_W'(1);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_ALLOC = 2'd2
    } cmd_t;

    // Request retiring from the compute stage, as seen by the open map.
    typedef struct packed {
        logic             retire;
        logic             set;
        logic             clear;
        logic [IDX_W-1:0] idx;
    } map_op_t;

    typedef struct packed {
        logic is_open;
        logic sweeping;
        logic epoch_last;
    } map_stat_t;

    function automatic logic fac_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(FACILITY_COUNT);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                                 input logic [COST_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// File: design/bblb_open_map.sv
// Open-facility map: one epoch mark per facility in a synchronous memory.
// Depends on bblb_pkg. Sweeps the memory after reset and on epoch wrap.
`timescale 1ns / 1ps

module bblb_open_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [bblb_pkg::IDX_W-1:0]    rd_idx,
    input  bblb_pkg::map_op_t             op,
    output bblb_pkg::map_stat_t           stat
);
    import bblb_pkg::*;

    logic [EPOCH_W-1:0] mem [MAP_DEPTH];
    logic [EPOCH_W-1:0] rd_epoch_reg;

    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               sweep_reg, sweep_next;
    logic [MAP_AW-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]   fwd_idx_reg, fwd_idx_next;

    logic               wr_en;
    logic [MAP_AW-1:0]  wr_addr;
    logic [EPOCH_W-1:0] wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = op.idx[MAP_AW-1:0];
        wr_data = epoch_reg;
        if (sweep_reg) begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
            wr_data = EPOCH_ZERO;
        end else if (op.retire && op.set) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_epoch_reg <= mem[rd_idx[MAP_AW-1:0]];
        end
    end

    always_comb begin
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_idx_next   = fwd_idx_reg;
        if (sweep_reg) begin
            sweep_cnt_next = sweep_cnt_reg + MAP_AW'(1);
            if (sweep_cnt_reg == MAP_AW'(MAP_DEPTH - 1)) begin
                sweep_next = 1'b0;
            end
        end
        if (op.retire) begin
            // The read of the next request may coincide with this write.
            fwd_valid_next = op.set;
            fwd_idx_next   = op.idx;
            if (op.clear) begin
                if (epoch_reg == EPOCH_LAST) begin
                    epoch_next     = EPOCH_ONE;
                    sweep_next     = 1'b1;
                    sweep_cnt_next = '0;
                end else begin
                    epoch_next = epoch_reg + EPOCH_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg     <= EPOCH_ONE;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            fwd_valid_reg <= fwd_valid_next;
        end
        fwd_idx_reg <= fwd_idx_next;
    end

    always_comb begin
        stat.is_open    = fac_in_range(op.idx) &&
                          ((rd_epoch_reg == epoch_reg) ||
                           (fwd_valid_reg && (fwd_idx_reg == op.idx)));
        stat.sweeping   = sweep_reg;
        stat.epoch_last = (epoch_reg == EPOCH_LAST);
    end

endmodule

// File: design/biobjective_lexmin_box_bounds_unit.sv
// Top level of the bi-objective box bounds unit.
// Depends on bblb_pkg, bblb_open_map and the assertion macro header.
`timescale 1ns / 1ps
`include "biobjective_lexmin_box_bounds_unit_macros.svh"

// Usage. Requests arrive on the s_ channel (valid/ready) and carry a command:
// clear the box, open a facility, or one allocation cost pair of the current
// customer. Every request yields exactly one result on the m_ channel: the six
// saturating box sums, the unassigned customer count, and whether this request
// closed a customer and whether that customer was trivially assigned.
// A request accepted into the compute stage moves into the output register once
// that register is free or being emptied, and its result then shows on the m_ ports.
// Throughput is one request per cycle while s_ready is high; the open map is a
// registered memory read at acceptance and written back when the request
// retires, with a one-entry forward for a read that coincides with that write.
// The map marks entries with an epoch, so a clear only advances the epoch. After
// reset, and after every 255th clear, the map is swept one entry per cycle over
// all 1024 entries (the map depth), during which s_ready is low; the wrapping
// clear also holds s_ready low while it waits in the compute stage. The customer
// total register may be written at any time through cfg_wr_en/cfg_wr_data.
// When the receiver stalls, the result is held in the output register and the
// next request waits in the compute stage; s_ready drops only once both are
// full. Reset is synchronous and active low and empties the box.

module biobjective_lexmin_box_bounds_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bblb_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [bblb_pkg::IDX_W-1:0]    s_facility_index,
    input  logic [bblb_pkg::COST_W-1:0]   s_cost_first,
    input  logic [bblb_pkg::COST_W-1:0]   s_cost_second,
    input  logic                          s_last_facility,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bblb_pkg::SUM_W-1:0]    m_lower_first,
    output logic [bblb_pkg::SUM_W-1:0]    m_lower_second,
    output logic [bblb_pkg::SUM_W-1:0]    m_upper_first,
    output logic [bblb_pkg::SUM_W-1:0]    m_upper_second,
    output logic [bblb_pkg::SUM_W-1:0]    m_origin_first,
    output logic [bblb_pkg::SUM_W-1:0]    m_origin_second,
    output logic [bblb_pkg::CNT_W-1:0]    m_unassigned_count,
    output logic                          m_customer_done,
    output logic                          m_customer_trivial
);
    import bblb_pkg::*;

    localparam int S_LF = 0;
    localparam int S_LS = 1;
    localparam int S_UF = 2;
    localparam int S_US = 3;
    localparam int S_OF = 4;
    localparam int S_OS = 5;

    // Configuration.
    logic [CNT_W-1:0] customer_total_reg;

    // Compute stage.
    logic              s1_valid_reg;
    logic [1:0]        s1_cmd_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [COST_W-1:0] s1_c0_reg, s1_c1_reg;
    logic              s1_last_reg;
    logic              s1_adv;
    logic              s_accept;

    // Architectural state.
    logic [COST_W-1:0] lf0_reg, lf1_reg, lf0_next, lf1_next;
    logic [COST_W-1:0] ls0_reg, ls1_reg, ls0_next, ls1_next;
    logic [1:0]        lex_valid_reg, lex_valid_next;
    logic [IDX_W-1:0]  bif_reg, bis_reg, bif_next, bis_next;
    logic [COST_W-1:0] bc0_reg, bc1_reg, bc0_next, bc1_next;
    logic [SUM_W-1:0]  sum_reg [6];
    logic [SUM_W-1:0]  sum_next [6];
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic              done_c, trivial_c;

    // Output register.
    logic              m_valid_reg;
    logic [SUM_W-1:0]  m_sum_reg [6];
    logic [CNT_W-1:0]  m_count_reg;
    logic              m_done_reg, m_trivial_reg;

    map_op_t           map_op;
    map_stat_t         map_stat;

    logic              upd, better_first, better_second;
    logic [COST_W-1:0] hi0, hi1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            customer_total_reg <= '0;
        end else if (cfg_wr_en) begin
            customer_total_reg <= cfg_wr_data;
        end
    end

    // Retire when the output register is free or being emptied. A clear that
    // wraps the epoch holds off new requests so none reads a stale map entry.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !map_stat.sweeping &&
                      !(s1_valid_reg && (s1_cmd_reg == CMD_CLEAR) && map_stat.epoch_last) &&
                      (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        map_op.retire = s1_adv;
        map_op.set    = (s1_cmd_reg == CMD_OPEN) && fac_in_range(s1_idx_reg);
        map_op.clear  = (s1_cmd_reg == CMD_CLEAR);
        map_op.idx    = s1_idx_reg;
    end

    bblb_open_map u_open_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_idx  (s_facility_index),
        .op      (map_op),
        .stat    (map_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            s1_cmd_reg  <= s_cmd;
            s1_idx_reg  <= s_facility_index;
            s1_c0_reg   <= s_cost_first;
            s1_c1_reg   <= s_cost_second;
            s1_last_reg <= s_last_facility;
        end
    end

    // Lexicographic minima: ties go to the later request.
    assign upd = (s1_cmd_reg == CMD_ALLOC) && map_stat.is_open;
    assign better_first  = !lex_valid_reg[0] || (s1_c0_reg < lf0_reg) ||
                           ((s1_c0_reg == lf0_reg) && (s1_c1_reg <= lf1_reg));
    assign better_second = !lex_valid_reg[1] || (s1_c1_reg < ls1_reg) ||
                           ((s1_c1_reg == ls1_reg) && (s1_c0_reg <= ls0_reg));

    always_comb begin
        lf0_next       = lf0_reg;
        lf1_next       = lf1_reg;
        ls0_next       = ls0_reg;
        ls1_next       = ls1_reg;
        lex_valid_next = lex_valid_reg;
        bif_next       = bif_reg;
        bis_next       = bis_reg;
        bc0_next       = bc0_reg;
        bc1_next       = bc1_reg;
        pending_next   = pending_reg;
        done_c         = 1'b0;
        trivial_c      = 1'b0;
        for (int i = 0; i < 6; i++) begin
            sum_next[i] = sum_reg[i];
        end

        if (upd && better_first) begin
            lf0_next          = s1_c0_reg;
            lf1_next          = s1_c1_reg;
            bif_next          = s1_idx_reg;
            bc0_next          = s1_c0_reg;
            bc1_next          = s1_c1_reg;
            lex_valid_next[0] = 1'b1;
        end
        if (upd && better_second) begin
            ls0_next          = s1_c0_reg;
            ls1_next          = s1_c1_reg;
            bis_next          = s1_idx_reg;
            lex_valid_next[1] = 1'b1;
        end

        hi0 = (lf0_next > ls0_next) ? lf0_next : ls0_next;
        hi1 = (lf1_next > ls1_next) ? lf1_next : ls1_next;

        case (s1_cmd_reg)
            CMD_CLEAR: begin
                for (int i = 0; i < 6; i++) begin
                    sum_next[i] = '0;
                end
                pending_next   = customer_total_reg;
                lex_valid_next = '0;
            end
            CMD_OPEN: begin
                if (fac_in_range(s1_idx_reg)) begin
                    for (int r = 0; r < 3; r++) begin
                        sum_next[2*r]   = sat_add(sum_reg[2*r], s1_c0_reg);
                        sum_next[2*r+1] = sat_add(sum_reg[2*r+1], s1_c1_reg);
                    end
                end
            end
            CMD_ALLOC: begin
                if (s1_last_reg) begin
                    done_c = 1'b1;
                    if (lex_valid_next == 2'b11) begin
                        if (bif_next == bis_next) begin
                            // One facility is best for both objectives.
                            trivial_c = 1'b1;
                            for (int r = 0; r < 3; r++) begin
                                sum_next[2*r]   = sat_add(sum_reg[2*r], bc0_next);
                                sum_next[2*r+1] = sat_add(sum_reg[2*r+1], bc1_next);
                            end
                            if (pending_reg != '0) begin
                                pending_next = pending_reg - CNT_W'(1);
                            end
                        end else begin
                            sum_next[S_LF] = sat_add(sum_reg[S_LF], lf0_next);
                            sum_next[S_LS] = sat_add(sum_reg[S_LS], ls1_next);
                            sum_next[S_UF] = sat_add(sum_reg[S_UF], hi0);
                            sum_next[S_US] = sat_add(sum_reg[S_US], hi1);
                        end
                    end
                    lex_valid_next = '0;
                end
            end
            default: begin
            end
        endcase

        // Closing or clearing resets the per-customer state.
        if (lex_valid_next == 2'b00) begin
            lf0_next = '0;
            lf1_next = '0;
            ls0_next = '0;
            ls1_next = '0;
            bif_next = '0;
            bis_next = '0;
            bc0_next = '0;
            bc1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lf0_reg       <= '0;
            lf1_reg       <= '0;
            ls0_reg       <= '0;
            ls1_reg       <= '0;
            lex_valid_reg <= '0;
            bif_reg       <= '0;
            bis_reg       <= '0;
            bc0_reg       <= '0;
            bc1_reg       <= '0;
            pending_reg   <= '0;
            for (int i = 0; i < 6; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            lf0_reg       <= lf0_next;
            lf1_reg       <= lf1_next;
            ls0_reg       <= ls0_next;
            ls1_reg       <= ls1_next;
            lex_valid_reg <= lex_valid_next;
            bif_reg       <= bif_next;
            bis_reg       <= bis_next;
            bc0_reg       <= bc0_next;
            bc1_reg       <= bc1_next;
            pending_reg   <= pending_next;
            for (int i = 0; i < 6; i++) begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (s1_adv) begin
            for (int i = 0; i < 6; i++) begin
                m_sum_reg[i] <= sum_next[i];
            end
            m_count_reg   <= pending_next;
            m_done_reg    <= done_c;
            m_trivial_reg <= trivial_c;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_lower_first      = m_sum_reg[S_LF];
    assign m_lower_second     = m_sum_reg[S_LS];
    assign m_upper_first      = m_sum_reg[S_UF];
    assign m_upper_second     = m_sum_reg[S_US];
    assign m_origin_first     = m_sum_reg[S_OF];
    assign m_origin_second    = m_sum_reg[S_OS];
    assign m_unassigned_count = m_count_reg;
    assign m_customer_done    = m_done_reg;
    assign m_customer_trivial = m_trivial_reg;

    // No request may enter while the map is being swept.
    `BBLB_ASSERT_IMP(a_no_accept_in_sweep, map_stat.sweeping, !s_ready, "request accepted during map sweep")

    // Lower bounds never pass upper bounds, saturation included.
    `BBLB_ASSERT_ALWAYS(a_lower_le_upper, (sum_reg[S_LF] <= sum_reg[S_UF]) && (sum_reg[S_LS] <= sum_reg[S_US]), "lower bound sum above upper bound sum")

    // A trivial customer takes one off the count unless it is already zero.
    `BBLB_ASSERT_NXT(a_trivial_count, s1_adv && trivial_c, ($past(pending_reg) == '0) || (pending_reg == $past(pending_reg) - CNT_W'(1)), "unassigned count not decremented")

    // Trivial is only reported on a closing result.
    `BBLB_ASSERT_IMP(a_trivial_done, s1_adv && trivial_c, done_c && (s1_cmd_reg == CMD_ALLOC) && s1_last_reg, "trivial flag without closing customer")

endmodule

// File: test/biobjective_lexmin_box_bounds_unit_tb.sv
// Self-checking testbench for the bi-objective box bounds unit.
// Depends on bblb_pkg, biobjective_lexmin_box_bounds_unit and the files that it needs.
`timescale 1ns / 1ps

module biobjective_lexmin_box_bounds_unit_tb;
    import bblb_pkg::*;

    // The command encoding leaves one value unused; the block must ignore it.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Positions of the six running sums, first objective then second.
    localparam int SUM_LOWER  = 0;
    localparam int SUM_UPPER  = 2;
    localparam int SUM_ORIGIN = 4;

    localparam logic [COST_W-1:0] COST_TOP = '1;
    localparam logic [SUM_W-1:0]  SUM_TOP  = '1;

    // Costs of one candidate: index 0 is the first objective, 1 the second.
    typedef logic [1:0][COST_W-1:0] cost_pair_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  facility_index;
        logic [COST_W-1:0] cost_first;
        logic [COST_W-1:0] cost_second;
        logic              last_facility;
    } request_t;

    typedef struct packed {
        logic [SUM_W-1:0] lower_first;
        logic [SUM_W-1:0] lower_second;
        logic [SUM_W-1:0] upper_first;
        logic [SUM_W-1:0] upper_second;
        logic [SUM_W-1:0] origin_first;
        logic [SUM_W-1:0] origin_second;
        logic [CNT_W-1:0] unassigned_count;
        logic             customer_done;
        logic             customer_trivial;
    } box_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_cmd = '0;
    logic [IDX_W-1:0]  s_facility_index = '0;
    logic [COST_W-1:0] s_cost_first = '0;
    logic [COST_W-1:0] s_cost_second = '0;
    logic              s_last_facility = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [SUM_W-1:0]  m_lower_first;
    logic [SUM_W-1:0]  m_lower_second;
    logic [SUM_W-1:0]  m_upper_first;
    logic [SUM_W-1:0]  m_upper_second;
    logic [SUM_W-1:0]  m_origin_first;
    logic [SUM_W-1:0]  m_origin_second;
    logic [CNT_W-1:0]  m_unassigned_count;
    logic              m_customer_done;
    logic              m_customer_trivial;

    biobjective_lexmin_box_bounds_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_facility_index   (s_facility_index),
        .s_cost_first       (s_cost_first),
        .s_cost_second      (s_cost_second),
        .s_last_facility    (s_last_facility),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_lower_first      (m_lower_first),
        .m_lower_second     (m_lower_second),
        .m_upper_first      (m_upper_first),
        .m_upper_second     (m_upper_second),
        .m_origin_first     (m_origin_first),
        .m_origin_second    (m_origin_second),
        .m_unassigned_count (m_unassigned_count),
        .m_customer_done    (m_customer_done),
        .m_customer_trivial (m_customer_trivial)
    );

    // ------------------------------------------------------------------
    // Predicted state of the box. It is advanced once per accepted request,
    // in acceptance order, so the expected results come out in the same
    // order as the block must deliver them.
    // ------------------------------------------------------------------
    logic [FACILITY_COUNT-1:0] open_facility;
    cost_pair_t                lex_best [2];   // per objective, first objective at index 0
    logic [1:0]                lex_ok;
    logic [IDX_W-1:0]          lex_index [2];
    logic [SUM_W-1:0]          box_sum [6];
    logic [CNT_W-1:0]          customers_left;
    logic [CNT_W-1:0]          customer_total;

    box_result_t expected_boxes [$];
    int          failures = 0;
    bit          idling = 1'b1;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Generous ceiling; a correct run finishes in a small fraction of it.
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // The receiver holds off at random, with a chance of 12 in 100, while idling is on.
    always @(negedge aclk) begin
        m_ready <= !(idling && $urandom_range(99) < 12);
    end

    function automatic logic [SUM_W-1:0] clamp_add(input logic [SUM_W-1:0]  acc,
                                                   input logic [COST_W-1:0] cost);
        if (acc > SUM_TOP - SUM_W'(cost))
            return SUM_TOP;
        return acc + SUM_W'(cost);
    endfunction

    function automatic void add_to_every_sum(input cost_pair_t pair);
        for (int r = 0; r < 6; r += 2) begin
            box_sum[r]     = clamp_add(box_sum[r], pair[0]);
            box_sum[r + 1] = clamp_add(box_sum[r + 1], pair[1]);
        end
    endfunction

    function automatic void forget_customer();
        for (int k = 0; k < 2; k++) begin
            lex_best[k]  = '0;
            lex_index[k] = '0;
        end
        lex_ok = '0;
    endfunction

    // A candidate takes over objective k when nothing is held yet, when it is
    // strictly cheaper on k, or when it ties on k and is no worse on the other
    // objective. Later items therefore win exact ties.
    function automatic logic lex_wins(input cost_pair_t held, input logic held_ok,
                                      input cost_pair_t cand, input int k);
        int other;
        other = 1 - k;
        if (!held_ok)
            return 1'b1;
        if (cand[k] < held[k])
            return 1'b1;
        return cand[k] == held[k] && cand[other] <= held[other];
    endfunction

    function automatic box_result_t step_box(input request_t rq);
        cost_pair_t       cand;
        logic             usable;
        logic [COST_W-1:0] lo;
        logic [COST_W-1:0] hi;
        box_result_t      res;
        cand[0] = rq.cost_first;
        cand[1] = rq.cost_second;
        usable  = int'(rq.facility_index) < FACILITY_COUNT;
        res     = '0;
        case (rq.cmd)
            CMD_CLEAR: begin
                open_facility = '0;
                for (int r = 0; r < 6; r++)
                    box_sum[r] = '0;
                forget_customer();
                customers_left = customer_total;
            end
            CMD_OPEN: begin
                if (usable) begin
                    open_facility[rq.facility_index] = 1'b1;
                    add_to_every_sum(cand);
                end
            end
            CMD_ALLOC: begin
                if (usable && open_facility[rq.facility_index]) begin
                    for (int k = 0; k < 2; k++) begin
                        if (lex_wins(lex_best[k], lex_ok[k], cand, k)) begin
                            lex_best[k]  = cand;
                            lex_index[k] = rq.facility_index;
                            lex_ok[k]    = 1'b1;
                        end
                    end
                end
                if (rq.last_facility) begin
                    res.customer_done = 1'b1;
                    // A customer that saw no open facility contributes nothing.
                    if (lex_ok == 2'b11) begin
                        if (lex_index[0] == lex_index[1]) begin
                            res.customer_trivial = 1'b1;
                            add_to_every_sum(lex_best[0]);
                            if (customers_left != 0)
                                customers_left--;
                        end else begin
                            for (int j = 0; j < 2; j++) begin
                                lo = lex_best[j][j];
                                hi = (lex_best[0][j] > lex_best[1][j]) ? lex_best[0][j]
                                                                       : lex_best[1][j];
                                box_sum[SUM_LOWER + j] = clamp_add(box_sum[SUM_LOWER + j], lo);
                                box_sum[SUM_UPPER + j] = clamp_add(box_sum[SUM_UPPER + j], hi);
                            end
                        end
                    end
                    forget_customer();
                end
            end
            default: ;
        endcase
        res.lower_first      = box_sum[SUM_LOWER];
        res.lower_second     = box_sum[SUM_LOWER + 1];
        res.upper_first      = box_sum[SUM_UPPER];
        res.upper_second     = box_sum[SUM_UPPER + 1];
        res.origin_first     = box_sum[SUM_ORIGIN];
        res.origin_second    = box_sum[SUM_ORIGIN + 1];
        res.unassigned_count = customers_left;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every accepted result is matched to the oldest
    // prediction still waiting.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [SUM_W-1:0] want,
                                        input logic [SUM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        box_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_boxes.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = expected_boxes.pop_front();
                check_field("m_lower_first", want.lower_first, m_lower_first);
                check_field("m_lower_second", want.lower_second, m_lower_second);
                check_field("m_upper_first", want.upper_first, m_upper_first);
                check_field("m_upper_second", want.upper_second, m_upper_second);
                check_field("m_origin_first", want.origin_first, m_origin_first);
                check_field("m_origin_second", want.origin_second, m_origin_second);
                check_field("m_unassigned_count", SUM_W'(want.unassigned_count),
                            SUM_W'(m_unassigned_count));
                check_field("m_customer_done", SUM_W'(want.customer_done),
                            SUM_W'(m_customer_done));
                check_field("m_customer_trivial", SUM_W'(want.customer_trivial),
                            SUM_W'(m_customer_trivial));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driving. Every task starts and ends on a falling edge; valid
    // is only lowered during a gap, so back-to-back requests keep it high.
    // ------------------------------------------------------------------
    function automatic request_t req(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                                     input logic [COST_W-1:0] c_first,
                                     input logic [COST_W-1:0] c_second, input logic last);
        request_t rq;
        rq.cmd            = cmd;
        rq.facility_index = idx;
        rq.cost_first     = c_first;
        rq.cost_second    = c_second;
        rq.last_facility  = last;
        return rq;
    endfunction

    task automatic send_request(input request_t rq);
        while (idling && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_cmd            <= rq.cmd;
        s_facility_index <= rq.facility_index;
        s_cost_first     <= rq.cost_first;
        s_cost_second    <= rq.cost_second;
        s_last_facility  <= rq.last_facility;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_boxes = {expected_boxes, step_box(rq)};
        @(negedge aclk);
    endtask

    // Every request yields a result, so an empty queue means the block is idle.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_customer_total(input logic [CNT_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        customer_total = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mixes wide random costs with tiny and near-maximum ones so that ties on
    // one or both objectives happen often.
    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return COST_W'($urandom_range(3));
            2:       return COST_TOP - COST_W'($urandom_range(3));
            default: return COST_W'($urandom_range(1000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked requests: empty customer, the unused command, reopening,
    // closed facilities, ties, a repeated index, a count stuck at zero, and
    // a small and the largest customer total.
    task automatic test_directed_cases();
        write_customer_total(16'd2);
        send_request(req(CMD_CLEAR, 10'd0, 32'd0, 32'd0, 1'b0));
        send_request(req(CMD_ALLOC, 10'd7, 32'd5, 32'd5, 1'b1));
        send_request(req(CMD_SPARE, 10'd1023, COST_TOP, COST_TOP, 1'b1));
        send_request(req(CMD_OPEN, 10'd0, 32'd10, 32'd20, 1'b0));
        send_request(req(CMD_OPEN, 10'd1023, COST_TOP, COST_TOP, 1'b1));
        send_request(req(CMD_OPEN, 10'd0, 32'd1, 32'd1, 1'b0));
        send_request(req(CMD_OPEN, 10'd512, 32'd0, 32'd0, 1'b0));
        // Trivial customer decided by a repeated index; facility 5 is closed.
        send_request(req(CMD_ALLOC, 10'd5, 32'd0, 32'd0, 1'b0));
        send_request(req(CMD_ALLOC, 10'd0, 32'd100, 32'd200, 1'b0));
        send_request(req(CMD_ALLOC, 10'd1023, 32'd100, 32'd300, 1'b0));
        send_request(req(CMD_ALLOC, 10'd0, 32'd50, 32'd50, 1'b1));
        // Incomparable pair with an exact tie going to the later facility.
        send_request(req(CMD_ALLOC, 10'd0, 32'd10, 32'd900, 1'b0));
        send_request(req(CMD_ALLOC, 10'd512, 32'd900, 32'd10, 1'b0));
        send_request(req(CMD_ALLOC, 10'd1023, 32'd10, 32'd900, 1'b1));
        // Closing on a closed facility still closes the customer.
        send_request(req(CMD_ALLOC, 10'd512, 32'd7, 32'd7, 1'b0));
        send_request(req(CMD_ALLOC, 10'd3, 32'd0, 32'd0, 1'b1));
        // The count is now zero and must stay there.
        send_request(req(CMD_ALLOC, 10'd1023, COST_TOP, 32'd0, 1'b0));
        send_request(req(CMD_ALLOC, 10'd0, COST_TOP, 32'd0, 1'b1));
        send_request(req(CMD_ALLOC, 10'd1023, COST_TOP, COST_TOP, 1'b1));
        write_customer_total(16'hFFFF);
        send_request(req(CMD_CLEAR, 10'd1023, COST_TOP, COST_TOP, 1'b1));
        send_request(req(CMD_OPEN, 10'd341, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        send_request(req(CMD_ALLOC, 10'd341, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    endtask

    // The map wraps its clear epoch every 255 clears; facilities opened
    // before a clear must read as closed afterwards across that wrap.
    task automatic test_clear_epoch_wrap();
        logic [IDX_W-1:0] prev_idx;
        logic [IDX_W-1:0] idx;
        prev_idx = '0;
        repeat (260) begin
            send_request(req(CMD_CLEAR, IDX_W'($urandom), $urandom, $urandom,
                             1'($urandom)));
            send_request(req(CMD_ALLOC, prev_idx, pick_cost(), pick_cost(), 1'b1));
            idx = IDX_W'($urandom);
            send_request(req(CMD_OPEN, idx, pick_cost(), pick_cost(), 1'b0));
            send_request(req(CMD_ALLOC, idx, pick_cost(), pick_cost(), 1'b1));
            prev_idx = idx;
        end
    endtask

    // Mostly well-formed phases: clear, open a handful of facilities, then
    // stream customers over them. Roughly one request in twelve is noise:
    // any command with random fields, a late open, or a stray allocation.
    task automatic test_random_customers();
        int               sent;
        int               phase;
        int               n_items;
        int               roll;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] opened [$];
        sent  = 0;
        phase = 0;
        while (sent < 450) begin
            case (phase % 5)
                0:       write_customer_total(16'hFFFF);
                1:       write_customer_total(16'd0);
                2:       write_customer_total(16'd1);
                default: write_customer_total(CNT_W'($urandom));
            endcase
            phase++;
            send_request(req(CMD_CLEAR, IDX_W'($urandom), $urandom, $urandom,
                             1'($urandom)));
            sent++;
            opened.delete();
            repeat ($urandom_range(1, 12)) begin
                idx = IDX_W'($urandom);
                opened = {opened, idx};
                send_request(req(CMD_OPEN, idx, pick_cost(), pick_cost(), 1'($urandom)));
                sent++;
            end
            repeat ($urandom_range(20, 60)) begin
                n_items = $urandom_range(1, 6);
                for (int i = 0; i < n_items; i++) begin
                    roll = $urandom_range(99);
                    if (roll < 3) begin
                        send_request(req(2'($urandom), IDX_W'($urandom), $urandom,
                                         $urandom, 1'($urandom)));
                    end else if (roll < 6) begin
                        idx = IDX_W'($urandom);
                        opened = {opened, idx};
                        send_request(req(CMD_OPEN, idx, pick_cost(), pick_cost(), 1'b0));
                    end else if (roll < 8) begin
                        send_request(req(CMD_ALLOC, IDX_W'($urandom), pick_cost(),
                                         pick_cost(), 1'($urandom)));
                    end else begin
                        if ($urandom_range(99) < 85)
                            idx = opened[$urandom_range(opened.size() - 1)];
                        else
                            idx = IDX_W'($urandom);
                        send_request(req(CMD_ALLOC, idx, pick_cost(), pick_cost(),
                                         i == n_items - 1));
                    end
                    sent++;
                end
            end
        end
    endtask

    // Piles the largest cost onto all six sums by reopening one facility many
    // times, carrying well into the upper bits, then closes both kinds of
    // customer on top of that. This is the long stretch without idling.
    task automatic test_large_costs();
        write_customer_total(16'd5);
        idling = 1'b0;
        send_request(req(CMD_CLEAR, 10'd0, 32'd0, 32'd0, 1'b0));
        repeat (160)
            send_request(req(CMD_OPEN, 10'd9, COST_TOP, COST_TOP, 1'b0));
        send_request(req(CMD_ALLOC, 10'd9, COST_TOP, COST_TOP, 1'b1));
        send_request(req(CMD_OPEN, 10'd10, 32'd1, 32'd1, 1'b0));
        send_request(req(CMD_ALLOC, 10'd10, 32'd1, 32'd2, 1'b0));
        send_request(req(CMD_ALLOC, 10'd9, 32'd2, 32'd1, 1'b1));
        idling = 1'b1;
    endtask

    initial begin
        open_facility  = '0;
        box_sum        = '{default: '0};
        customers_left = '0;
        customer_total = '0;
        forget_customer();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_clear_epoch_wrap();
        test_random_customers();
        test_large_costs();

        wait_for_results();
        repeat (16) @(posedge aclk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/bblb_pkg.sv
design/bblb_open_map.sv
design/biobjective_lexmin_box_bounds_unit.sv
test/biobjective_lexmin_box_bounds_unit_tb.sv
